// ===== hw/rtl/idls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idls_pkg
// Shared constants, codes, types and character helpers for the identity line
// field splitter.
// ----------------------------------------------------------------------------
package idls_pkg;

    localparam int MAX_LINE = 4096;
    localparam int POS_W    = $clog2(MAX_LINE + 2);
    localparam int OFS_W    = 13;

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LINE);
    localparam logic [POS_W-1:0] POS_OVER  = POS_W'(MAX_LINE + 1);

    // parse phase
    localparam logic [1:0] PH_SEEK_OPEN  = 2'd0;
    localparam logic [1:0] PH_SEEK_CLOSE = 2'd1;
    localparam logic [1:0] PH_TAIL       = 2'd2;

    // tail tracker state
    localparam logic [2:0] TS_IDLE = 3'd0;
    localparam logic [2:0] TS_WS1  = 3'd1;
    localparam logic [2:0] TS_DATE = 3'd2;
    localparam logic [2:0] TS_WS2  = 3'd3;
    localparam logic [2:0] TS_SIGN = 3'd4;
    localparam logic [2:0] TS_ZONE = 3'd5;
    localparam logic [2:0] TS_DONE = 3'd6;
    localparam logic [2:0] TS_FAIL = 3'd7;

    // result status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_OPEN  = 2'd1;
    localparam logic [1:0] ST_NO_CLOSE = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;

    typedef struct packed {
        logic             en;
        logic             clear;
        logic [7:0]       text;
        logic [POS_W-1:0] pos;
    } t_tail_step;

    typedef struct packed {
        logic [2:0]       state;
        logic [POS_W-1:0] date_start;
        logic [POS_W-1:0] date_stop;
        logic [POS_W-1:0] zone_start;
        logic [POS_W-1:0] zone_stop;
    } t_tail_info;

    typedef struct packed {
        logic [1:0]       status;
        logic             has_date;
        logic [OFS_W-1:0] name_stop;
        logic [OFS_W-1:0] mail_start;
        logic [OFS_W-1:0] mail_stop;
        logic [OFS_W-1:0] date_start;
        logic [OFS_W-1:0] date_stop;
        logic [OFS_W-1:0] zone_start;
        logic [OFS_W-1:0] zone_stop;
    } t_result;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    function automatic logic [OFS_W-1:0] to_ofs(input logic [POS_W-1:0] p);
        return OFS_W'(p);
    endfunction

endpackage

// ===== hw/rtl/idls_tail.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idls_tail
// Tracks the date and zone fields that follow the last closing bracket and
// exposes the updated state and offsets for the current byte.
// ----------------------------------------------------------------------------
module idls_tail (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  idls_pkg::t_tail_step i_step,
    output idls_pkg::t_tail_info o_tail
);
    import idls_pkg::*;

    logic [2:0]       r_state, n_state;
    logic [POS_W-1:0] r_date_start, n_date_start;
    logic [POS_W-1:0] r_date_stop,  n_date_stop;
    logic [POS_W-1:0] r_zone_start, n_zone_start;
    logic [POS_W-1:0] r_zone_stop,  n_zone_stop;

    always_comb begin
        n_state      = r_state;
        n_date_start = r_date_start;
        n_date_stop  = r_date_stop;
        n_zone_start = r_zone_start;
        n_zone_stop  = r_zone_stop;
        if (i_step.en) begin
            if (i_step.text == CH_GT) begin
                // a later '>' restarts the tail
                n_state      = TS_WS1;
                n_date_start = '0;
                n_date_stop  = '0;
                n_zone_start = '0;
                n_zone_stop  = '0;
            end else begin
                unique case (r_state) inside
                    TS_WS1: begin
                        if (is_digit(i_step.text)) begin
                            n_date_start = i_step.pos;
                            n_state      = TS_DATE;
                        end else if (!is_ws(i_step.text)) begin
                            n_state = TS_FAIL;
                        end
                    end
                    TS_DATE: begin
                        if (!is_digit(i_step.text)) begin
                            n_date_stop = i_step.pos;
                            if (is_ws(i_step.text)) begin
                                n_state = TS_WS2;
                            end else if (is_sign(i_step.text)) begin
                                n_zone_start = i_step.pos;
                                n_state      = TS_SIGN;
                            end else begin
                                n_state = TS_FAIL;
                            end
                        end
                    end
                    TS_WS2: begin
                        if (is_sign(i_step.text)) begin
                            n_zone_start = i_step.pos;
                            n_state      = TS_SIGN;
                        end else if (!is_ws(i_step.text)) begin
                            n_state = TS_FAIL;
                        end
                    end
                    TS_SIGN: begin
                        n_state = is_digit(i_step.text) ? TS_ZONE : TS_FAIL;
                    end
                    TS_ZONE: begin
                        if (!is_digit(i_step.text)) begin
                            n_zone_stop = i_step.pos;
                            n_state     = TS_DONE;
                        end
                    end
                    TS_IDLE, TS_DONE, TS_FAIL: begin
                        n_state = r_state;
                    end
                    default: begin
                        n_state = r_state;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_step.clear) begin
            r_state      <= TS_IDLE;
            r_date_start <= '0;
            r_date_stop  <= '0;
            r_zone_start <= '0;
            r_zone_stop  <= '0;
        end else begin
            r_state      <= n_state;
            r_date_start <= n_date_start;
            r_date_stop  <= n_date_stop;
            r_zone_start <= n_zone_start;
            r_zone_stop  <= n_zone_stop;
        end
    end

    assign o_tail.state      = n_state;
    assign o_tail.date_start = n_date_start;
    assign o_tail.date_stop  = n_date_stop;
    assign o_tail.zone_start = n_zone_start;
    assign o_tail.zone_stop  = n_zone_stop;

endmodule

// ===== hw/rtl/idls_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idls_scan
// Per-byte line scanner: byte position, bracket search, held offsets, and
// the result word formed on the line's final byte.
// ----------------------------------------------------------------------------
module idls_scan (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_text_byte,
    input  logic              i_line_end,
    output logic              o_push,
    output idls_pkg::t_result o_result
);
    import idls_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [1:0]       r_phase, n_phase;
    logic             r_nul_seen, n_nul_seen;
    logic [POS_W-1:0] r_name_stop, n_name_stop;
    logic [POS_W-1:0] r_mail_start, n_mail_start;
    logic [POS_W-1:0] r_mail_stop, n_mail_stop;
    logic             pos_ok;
    logic             line_done;
    logic             dated;
    logic [POS_W-1:0] zone_stop;
    t_tail_step       tail_step;
    t_tail_info       tail;

    assign pos_ok    = r_pos < POS_LIMIT;
    assign line_done = i_accept && i_line_end;

    always_comb begin
        n_pos        = r_pos;
        n_phase      = r_phase;
        n_nul_seen   = r_nul_seen;
        n_name_stop  = r_name_stop;
        n_mail_start = r_mail_start;
        n_mail_stop  = r_mail_stop;
        if (i_accept) begin
            if (pos_ok) begin
                n_pos = r_pos + POS_W'(1);
                unique case (r_phase)
                    PH_SEEK_OPEN: begin
                        if (!r_nul_seen) begin
                            if (i_text_byte == CH_NUL) begin
                                n_nul_seen = 1'b1;
                            end else if (i_text_byte == CH_LT) begin
                                n_mail_start = r_pos + POS_W'(1);
                                n_phase      = PH_SEEK_CLOSE;
                            end else if (!is_ws(i_text_byte)) begin
                                n_name_stop = r_pos + POS_W'(1);
                            end
                        end
                    end
                    PH_SEEK_CLOSE: begin
                        if (i_text_byte == CH_GT) begin
                            n_mail_stop = r_pos;
                            n_phase     = PH_TAIL;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end else begin
                n_pos = POS_OVER;
            end
        end
    end

    assign tail_step.en    = i_accept && pos_ok &&
                             (((r_phase == PH_SEEK_CLOSE) && (i_text_byte == CH_GT)) ||
                              (r_phase == PH_TAIL));
    assign tail_step.clear = line_done;
    assign tail_step.text  = i_text_byte;
    assign tail_step.pos   = r_pos;

    idls_tail u_tail (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (tail_step),
        .o_tail  (tail)
    );

    // zone digits running to the line end close at the line length
    assign zone_stop = (tail.state == TS_ZONE) ? n_pos : tail.zone_stop;

    always_comb begin
        o_result = '0;
        dated    = 1'b0;
        if (n_pos > POS_LIMIT) begin
            o_result.status = ST_TOO_LONG;
        end else begin
            unique case (n_phase)
                PH_SEEK_OPEN: begin
                    o_result.status = ST_NO_OPEN;
                end
                PH_SEEK_CLOSE: begin
                    o_result.status     = ST_NO_CLOSE;
                    o_result.name_stop  = to_ofs(n_name_stop);
                    o_result.mail_start = to_ofs(n_mail_start);
                end
                default: begin
                    dated               = (tail.state == TS_ZONE) ||
                                          (tail.state == TS_DONE);
                    o_result.status     = ST_OK;
                    o_result.has_date   = dated;
                    o_result.name_stop  = to_ofs(n_name_stop);
                    o_result.mail_start = to_ofs(n_mail_start);
                    o_result.mail_stop  = to_ofs(n_mail_stop);
                    if (dated) begin
                        o_result.date_start = to_ofs(tail.date_start);
                        o_result.date_stop  = to_ofs(tail.date_stop);
                        o_result.zone_start = to_ofs(tail.zone_start);
                        o_result.zone_stop  = to_ofs(zone_stop);
                    end
                end
            endcase
        end
    end

    assign o_push = line_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || line_done) begin
            r_pos        <= '0;
            r_phase      <= PH_SEEK_OPEN;
            r_nul_seen   <= 1'b0;
            r_name_stop  <= '0;
            r_mail_start <= '0;
            r_mail_stop  <= '0;
        end else begin
            r_pos        <= n_pos;
            r_phase      <= n_phase;
            r_nul_seen   <= n_nul_seen;
            r_name_stop  <= n_name_stop;
            r_mail_start <= n_mail_start;
            r_mail_stop  <= n_mail_stop;
        end
    end

endmodule

// ===== hw/rtl/idls_obuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idls_obuf
// Result register with a skid entry behind it; raises full only while both
// hold a result.
// ----------------------------------------------------------------------------
module idls_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  idls_pkg::t_result i_result,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output idls_pkg::t_result o_result
);
    import idls_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= i_push;
            end else begin
                r_out_valid  <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (i_push) begin
                    r_skid <= i_result;
                end
            end else if (i_push) begin
                r_out <= i_result;
            end
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty result register");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid)
        else $error("result pushed while buffer full");

    a_stalled_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> r_out_valid)
        else $error("stalled result dropped");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> r_out_valid)
        else $error("skid entry lost on drain");

endmodule

// ===== hw/rtl/ident_line_field_splitter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ident_line_field_splitter_unit
// Splits an identity line, one byte per transaction, into name, mail, date
// and zone offsets, giving one result per line.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; o_stall rises only when two results wait.
// The result of a line is registered into the result register or skid entry.
// Each byte is scanned combinationally against the running line state.
// Reset (synchronous, active low) clears the line state and empties the
// result register and its skid entry.
module ident_line_field_splitter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_line_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic        o_has_date,
    output logic [12:0] o_name_stop,
    output logic [12:0] o_mail_start,
    output logic [12:0] o_mail_stop,
    output logic [12:0] o_date_start,
    output logic [12:0] o_date_stop,
    output logic [12:0] o_zone_start,
    output logic [12:0] o_zone_stop
);
    import idls_pkg::*;

    logic    accept;
    logic    push;
    logic    full;
    t_result scan_result;
    t_result out_result;

    assign accept  = i_valid && !full;
    assign o_stall = full;

    idls_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_text_byte (i_text_byte),
        .i_line_end  (i_line_end),
        .o_push      (push),
        .o_result    (scan_result)
    );

    idls_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (scan_result),
        .o_full   (full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_result)
    );

    assign o_status     = out_result.status;
    assign o_has_date   = out_result.has_date;
    assign o_name_stop  = out_result.name_stop;
    assign o_mail_start = out_result.mail_start;
    assign o_mail_stop  = out_result.mail_stop;
    assign o_date_start = out_result.date_start;
    assign o_date_stop  = out_result.date_stop;
    assign o_zone_start = out_result.zone_start;
    assign o_zone_stop  = out_result.zone_stop;

endmodule

// ===== tb/ident_line_field_splitter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ident_line_field_splitter_unit_tb
// Drives identity lines into the splitter one byte per transaction and checks
// every line result field by field. A short table of hand-written lines comes
// first; some rows carry their expected result, the others and the random
// lines after them are checked against a behavioural line scanner. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module ident_line_field_splitter_unit_tb;

    import idls_pkg::*;

    localparam int      WATCHDOG_LIMIT = 200;
    localparam int      DRAIN_CYCLES   = 20;
    localparam int      RANDOM_BYTES   = 2000;
    localparam int      N_DIR          = 22;
    localparam t_result UNTYPED        = '0;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [7:0]  i_text_byte  = 8'h00;
    logic        i_line_end   = 1'b0;
    logic        i_stall      = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_status;
    logic        o_has_date;
    logic [12:0] o_name_stop;
    logic [12:0] o_mail_start;
    logic [12:0] o_mail_stop;
    logic [12:0] o_date_start;
    logic [12:0] o_date_stop;
    logic [12:0] o_zone_start;
    logic [12:0] o_zone_stop;

    ident_line_field_splitter_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_text_byte  (i_text_byte),
        .i_line_end   (i_line_end),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_has_date   (o_has_date),
        .o_name_stop  (o_name_stop),
        .o_mail_start (o_mail_start),
        .o_mail_stop  (o_mail_stop),
        .o_date_start (o_date_start),
        .o_date_stop  (o_date_stop),
        .o_zone_start (o_zone_start),
        .o_zone_stop  (o_zone_stop)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // '^' in a row stands for NUL; rows are padded with '7' up to the pad length
    string dir_text [N_DIR] = '{
        "A <a@b> 1 +0",
        "no bracket",
        "Ab <x",
        "N^ <m> 1 +1",
        "<>",
        "<",
        "x",
        "N <m> 1 +",
        "N <m> 1 +",
        "N <m> 1 +0",
        "N \t<m>1+0 ",
        "N <m> 12 -0100 x",
        "N <m> 1 +",
        "N <m> x",
        "N <a> <b> 5 +3",
        "N <m>123",
        "N <m> 1 +0\r\n",
        "N <m> 1 +0>",
        " \t\r\n<m>  1\t-9",
        "N<m^>1 +2",
        "N <m> +0100",
        "N <m>> 1 +0"
    };
    int dir_pad [N_DIR] = '{
        0, 0, 0, 0, 0, 0, 0, 4096, 4097, 4100, 0,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };
    t_result dir_want [N_DIR] = '{
        '{ST_OK, 1'b1, 13'd1, 13'd3, 13'd6, 13'd8, 13'd9, 13'd10, 13'd12},
        '{ST_NO_OPEN, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0},
        '{ST_NO_CLOSE, 1'b0, 13'd2, 13'd4, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0},
        '{ST_NO_OPEN, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0},
        '{ST_OK, 1'b0, 13'd0, 13'd1, 13'd1, 13'd0, 13'd0, 13'd0, 13'd0},
        '{ST_NO_CLOSE, 1'b0, 13'd0, 13'd1, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0},
        '{ST_NO_OPEN, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0},
        '{ST_OK, 1'b1, 13'd1, 13'd3, 13'd4, 13'd6, 13'd7, 13'd8, 13'd4096},
        '{ST_TOO_LONG, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0},
        '{ST_TOO_LONG, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0},
        UNTYPED, UNTYPED, UNTYPED, UNTYPED, UNTYPED, UNTYPED,
        UNTYPED, UNTYPED, UNTYPED, UNTYPED, UNTYPED, UNTYPED
    };

    // line scanner state
    logic [12:0] line_pos;
    logic [1:0]  line_phase;
    logic        saw_nul;
    logic [12:0] name_hi;
    logic [12:0] mail_lo;
    logic [12:0] mail_hi;
    logic [2:0]  tail_st;
    logic [12:0] tail_ofs [4];

    t_result expected_splits [$];
    int      mismatch_count = 0;
    int      idle_cycles    = 0;
    bit      no_gaps        = 1'b0;

    function automatic logic blank_char(input logic [7:0] c);
        return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic sign_char(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS;
    endfunction

    function automatic logic [7:0] ws_byte();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: c = CH_SP;
            1: c = CH_TAB;
            2: c = CH_LF;
            default: c = CH_CR;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] digit_byte();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] plain_byte(input logic [7:0] avoid);
        logic [7:0] c;
        int         r;
        r = $urandom_range(0, 15);
        if (r == 0) begin
            c = 8'($urandom_range(0, 255));
        end else if (r == 1) begin
            c = ws_byte();
        end else begin
            c = 8'($urandom_range(8'h21, 8'h7E));
            if (c == avoid) begin
                c = "x";
            end
        end
        return c;
    endfunction

    task automatic clear_line_state();
        line_pos   = '0;
        line_phase = PH_SEEK_OPEN;
        saw_nul    = 1'b0;
        name_hi    = '0;
        mail_lo    = '0;
        mail_hi    = '0;
        tail_st    = TS_IDLE;
        tail_ofs   = '{default: '0};
    endtask

    task automatic advance_tail(input logic [7:0] c, input logic [12:0] at);
        if (c == CH_GT) begin
            tail_st  = TS_WS1;
            tail_ofs = '{default: '0};
        end else begin
            case (tail_st)
                TS_WS1: begin
                    if (digit_char(c)) begin
                        tail_ofs[0] = at;
                        tail_st     = TS_DATE;
                    end else if (!blank_char(c)) begin
                        tail_st = TS_FAIL;
                    end
                end
                TS_DATE: begin
                    if (!digit_char(c)) begin
                        tail_ofs[1] = at;
                        if (blank_char(c)) begin
                            tail_st = TS_WS2;
                        end else if (sign_char(c)) begin
                            tail_ofs[2] = at;
                            tail_st     = TS_SIGN;
                        end else begin
                            tail_st = TS_FAIL;
                        end
                    end
                end
                TS_WS2: begin
                    if (sign_char(c)) begin
                        tail_ofs[2] = at;
                        tail_st     = TS_SIGN;
                    end else if (!blank_char(c)) begin
                        tail_st = TS_FAIL;
                    end
                end
                TS_SIGN: begin
                    tail_st = digit_char(c) ? TS_ZONE : TS_FAIL;
                end
                TS_ZONE: begin
                    if (!digit_char(c)) begin
                        tail_ofs[3] = at;
                        tail_st     = TS_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
    endtask

    task automatic scan_ident_byte(input logic [7:0] c, input logic last,
                                   output bit produced, output t_result res);
        logic [12:0] at;
        logic [12:0] len;
        logic        dated;
        at       = line_pos;
        produced = 1'b0;
        res      = '0;
        dated    = 1'b0;
        if (at < MAX_LINE) begin
            case (line_phase)
                PH_SEEK_OPEN: begin
                    if (!saw_nul) begin
                        if (c == CH_NUL) begin
                            saw_nul = 1'b1;
                        end else if (c == CH_LT) begin
                            mail_lo    = at + 13'd1;
                            line_phase = PH_SEEK_CLOSE;
                        end else if (!blank_char(c)) begin
                            name_hi = at + 13'd1;
                        end
                    end
                end
                PH_SEEK_CLOSE: begin
                    if (c == CH_GT) begin
                        mail_hi    = at;
                        line_phase = PH_TAIL;
                        advance_tail(c, at);
                    end
                end
                default: begin
                    advance_tail(c, at);
                end
            endcase
            line_pos = at + 13'd1;
        end else begin
            line_pos = 13'(MAX_LINE + 1);
        end
        if (last) begin
            produced = 1'b1;
            len      = line_pos;
            if (len > MAX_LINE) begin
                res.status = ST_TOO_LONG;
            end else if (line_phase == PH_SEEK_OPEN) begin
                res.status = ST_NO_OPEN;
            end else if (line_phase == PH_SEEK_CLOSE) begin
                res.status     = ST_NO_CLOSE;
                res.name_stop  = name_hi;
                res.mail_start = mail_lo;
            end else begin
                res.status     = ST_OK;
                res.name_stop  = name_hi;
                res.mail_start = mail_lo;
                res.mail_stop  = mail_hi;
                if (tail_st == TS_ZONE) begin
                    tail_ofs[3] = len;
                    dated       = 1'b1;
                end else if (tail_st == TS_DONE) begin
                    dated = 1'b1;
                end
                if (dated) begin
                    res.date_start = tail_ofs[0];
                    res.date_stop  = tail_ofs[1];
                    res.zone_start = tail_ofs[2];
                    res.zone_stop  = tail_ofs[3];
                end
            end
            res.has_date = dated;
            clear_line_state();
        end
    endtask

    task automatic log_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic cmp_field(input string name, input logic [12:0] got,
                             input logic [12:0] want);
        if (got !== want) begin
            log_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    task automatic check_split(input t_result got);
        t_result want;
        if (expected_splits.size() == 0) begin
            log_mismatch("result with no line pending");
        end else begin
            want = expected_splits.pop_front();
            cmp_field("status", 13'(got.status), 13'(want.status));
            cmp_field("has_date", 13'(got.has_date), 13'(want.has_date));
            cmp_field("name_stop", got.name_stop, want.name_stop);
            cmp_field("mail_start", got.mail_start, want.mail_start);
            cmp_field("mail_stop", got.mail_stop, want.mail_stop);
            cmp_field("date_start", got.date_start, want.date_start);
            cmp_field("date_stop", got.date_stop, want.date_stop);
            cmp_field("zone_start", got.zone_start, want.zone_start);
            cmp_field("zone_stop", got.zone_stop, want.zone_stop);
        end
    endtask

    // called just after a rising edge; returns just after the accepting edge
    task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                             input t_result want);
        int      gap;
        bit      produced;
        t_result guess;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_text_byte <= b;
        i_line_end  <= last;
        do @(posedge i_clk); while (o_stall);
        scan_ident_byte(b, last, produced, guess);
        if (produced) begin
            expected_splits.push_back(typed ? want : guess);
        end
    endtask

    task automatic send_line(input logic [7:0] q [$], input bit typed, input t_result want);
        for (int i = 0; i < q.size(); i++) begin
            send_byte(q[i], i == q.size() - 1, typed, want);
        end
    endtask

    initial begin
        t_result got;
        int      hold;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = no_gaps ? 0 : $urandom_range(0, 3);
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
            got.status     = o_status;
            got.has_date   = o_has_date;
            got.name_stop  = o_name_stop;
            got.mail_start = o_mail_start;
            got.mail_stop  = o_mail_stop;
            got.date_start = o_date_start;
            got.date_stop  = o_date_stop;
            got.zone_start = o_zone_start;
            got.zone_stop  = o_zone_stop;
            check_split(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [7:0] line [$];
        int         kind;
        int         sent;
        clear_line_state();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            line.delete();
            for (int k = 0; k < dir_text[i].len(); k++) begin
                line.push_back(dir_text[i][k] == "^" ? CH_NUL : dir_text[i][k]);
            end
            while (line.size() < dir_pad[i]) begin
                line.push_back("7");
            end
            send_line(line, dir_want[i] != UNTYPED, dir_want[i]);
        end

        sent = 0;
        while (sent < RANDOM_BYTES) begin
            line.delete();
            no_gaps = ($urandom_range(0, 5) == 0);
            kind    = $urandom_range(0, 9);
            if (kind == 9) begin
                repeat ($urandom_range(1, 24)) line.push_back(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(0, 6)) line.push_back(plain_byte(CH_LT));
                repeat ($urandom_range(0, 2)) line.push_back(ws_byte());
                line.push_back(CH_LT);
                repeat ($urandom_range(0, 6)) line.push_back(plain_byte(CH_GT));
                // kind 8 leaves the mail open
                if (kind != 8) begin
                    line.push_back(CH_GT);
                    repeat ($urandom_range(0, 2)) line.push_back(ws_byte());
                    repeat ($urandom_range(kind == 7 ? 0 : 1, 5)) line.push_back(digit_byte());
                    repeat ($urandom_range(0, 2)) line.push_back(ws_byte());
                    line.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                    repeat ($urandom_range(kind == 7 ? 0 : 1, 4)) line.push_back(digit_byte());
                    if ($urandom_range(0, 3) == 0) begin
                        repeat ($urandom_range(1, 3)) line.push_back(8'($urandom_range(0, 255)));
                    end
                end
                if (kind == 6) begin
                    line[$urandom_range(0, line.size() - 1)] = 8'($urandom_range(0, 255));
                end
            end
            send_line(line, 1'b0, UNTYPED);
            sent += line.size();
        end
        i_valid <= 1'b0;
        no_gaps = 1'b0;

        while (expected_splits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/idls_pkg.sv
hw/rtl/idls_tail.sv
hw/rtl/idls_scan.sv
hw/rtl/idls_obuf.sv
hw/rtl/ident_line_field_splitter_unit.sv
tb/ident_line_field_splitter_unit_tb.sv
